>>> hdl/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared widths, quaternion product term table and saturation helpers for
// the teleoperation pose mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

  localparam int ACCW   = 60;  // accumulator
  localparam int MW     = 35;  // multiplier operand
  localparam int QDW    = 35;  // first quaternion product
  localparam int QTW    = 54;  // second quaternion product
  localparam int SQW    = 60;  // square root radicand
  localparam int SQR    = 30;  // square root result
  localparam int DIV_NW = 50;  // dividend
  localparam int DIV_DW = 31;  // divisor

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } qterm_t;

  // term t of component j of a * b
  function automatic qterm_t qmul_term(input logic [1:0] j, input logic [1:0] t);
    qterm_t r;
    r.ai = t;
    r.bi = j ^ t;
    case ({j, t})
      4'b0001, 4'b0010, 4'b0011: r.neg = 1'b1;
      4'b0111:                   r.neg = 1'b1;
      4'b1001:                   r.neg = 1'b1;
      4'b1110:                   r.neg = 1'b1;
      default:                   r.neg = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // apply sign to an unsigned quotient and saturate
  function automatic logic signed [15:0] sat_q16(input logic neg,
                                                 input logic [DIV_NW-1:0] q);
    logic signed [15:0] r;
    if (neg) begin
      if (q >= DIV_NW'(32768)) begin
        r = -16'sh8000;
      end else begin
        r = -$signed(q[15:0]);
      end
    end else begin
      if (q >= DIV_NW'(32767)) begin
        r = 16'sh7FFF;
      end else begin
        r = $signed(q[15:0]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tpm_isqrt.sv
// ----------------------------------------------------------------------------
// tpm_isqrt
// Bit-pair integer square root, one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpm_isqrt (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [tpm_pkg::SQW-1:0]      x_i,
  output logic                         done_o,
  output logic [tpm_pkg::SQR-1:0]      root_o
);

  logic [tpm_pkg::SQW-1:0] x_q, res_q, bit_q, sum;
  logic                    busy_q, done_q;

  assign sum = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= x_i;
        res_q  <= '0;
        bit_q  <= tpm_pkg::SQW'(1) << (tpm_pkg::SQW - 2);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (x_q >= sum) begin
          x_q   <= x_q - sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == tpm_pkg::SQW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[tpm_pkg::SQR-1:0];

endmodule

`default_nettype wire

>>> hdl/tpm_div.sv
// ----------------------------------------------------------------------------
// tpm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpm_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [tpm_pkg::DIV_NW-1:0]   num_i,
  input  wire  [tpm_pkg::DIV_DW-1:0]   den_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [tpm_pkg::DIV_NW-1:0]   quo_o
);

  localparam int CW = $clog2(tpm_pkg::DIV_NW + 1);

  logic [tpm_pkg::DIV_DW-1:0] rem_q, den_q;
  logic [tpm_pkg::DIV_NW-1:0] quo_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;
  logic [tpm_pkg::DIV_DW:0]   trial, diff;
  logic                       ge;

  assign trial = {rem_q, quo_q[tpm_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
        cnt_q  <= CW'(tpm_pkg::DIV_NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[tpm_pkg::DIV_DW-1:0] : trial[tpm_pkg::DIV_DW-1:0];
        quo_q <= {quo_q[tpm_pkg::DIV_NW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> hdl/teleop_pose_mapper_safety_sphere.sv
// ----------------------------------------------------------------------------
// teleop_pose_mapper_safety_sphere
// Maps haptic pose samples to robot target poses with safety sphere clipping.
// ----------------------------------------------------------------------------
// One transaction at a time: a pose sample is accepted only once the last
// result is in the output register. The 50-step divider runs per quaternion
// component and, when the target is clipped, per position coordinate, beside
// the 30-step square root; all products go through one 35x35 multiplier.
// Reset clears the start strobes, the sequencer and the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module teleop_pose_mapper_safety_sphere #(
  parameter int POS_FRAC_BITS  = 13,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // pose_x, pose_y, pose_z, pose_qw, pose_qx, pose_qy, pose_qz
  input  wire  [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // target_x, target_y, target_z, target_qw, target_qx, target_qy, target_qz
  output logic [111:0] m_axis_tdata,
  // clipped
  output logic [0:0]   m_axis_tuser,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i
);

  localparam int ACCW = tpm_pkg::ACCW;
  localparam int MW   = tpm_pkg::MW;
  localparam int NW   = tpm_pkg::DIV_NW;
  localparam int RMAX = 2 << POS_FRAC_BITS;
  localparam int QONE_I = ((1 << QUAT_FRAC_BITS) > 32767) ? 32767 : (1 << QUAT_FRAC_BITS);
  localparam logic [15:0] QONE = 16'(QONE_I);
  localparam logic [tpm_pkg::QTW-1:0] NORM_HI = tpm_pkg::QTW'(1) << 28;
  localparam logic [tpm_pkg::QTW-1:0] NORM_LO = tpm_pkg::QTW'(1) << 27;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_DECIDE, ST_SQP, ST_PMUL, ST_PDIV, ST_QD, ST_QT,
    ST_MAX, ST_NORM, ST_N2, ST_SQQ, ST_QDS, ST_QDIV, ST_OUT
  } state_e;

  state_e state_q;
  logic [3:0] cnt_q;
  logic       ph_q;

  logic        en_q;
  logic [14:0] rad_q;
  logic signed [15:0] rs_q [3];
  logic [31:0] qwx_q, qyz_q;

  logic        seen_q;
  logic signed [15:0] hs_q [3];
  logic signed [15:0] prev_q [3];
  logic signed [15:0] anch_q [3];
  logic signed [15:0] qs_q [4];
  logic signed [15:0] qcur_q [4];
  logic signed [17:0] cand_q [3];
  logic signed [18:0] tgt_q [3];
  logic        clip_q;
  logic [29:0] rr_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [tpm_pkg::QDW-1:0] qd_q [4];
  logic signed [tpm_pkg::QTW-1:0] qt_q [4];
  logic [tpm_pkg::QTW-1:0] mag_q [4];
  logic [3:0]  qneg_q;
  logic [tpm_pkg::QTW-1:0] mmax_q;
  logic [tpm_pkg::SQR-1:0] n_q;
  logic        pneg_q;
  logic signed [15:0] qn_q [4];
  logic        m_valid_q;
  logic [111:0] m_data_q;
  logic        m_user_q;

  logic sq_start_q, sq_done;
  logic [tpm_pkg::SQW-1:0] sq_x_q;
  logic [tpm_pkg::SQR-1:0] sq_root;
  logic dv_start_q, dv_busy, dv_done;
  logic [NW-1:0] dv_num_q, dv_quo;
  logic [tpm_pkg::DIV_DW-1:0] dv_den_q;

  logic signed [15:0] cur [3];
  logic signed [15:0] qin [4];
  logic signed [15:0] hs_e [3], prev_e [3], anch_e [3];
  logic signed [17:0] cand_d [3];
  logic signed [18:0] tgt_d [3];
  logic signed [15:0] qee [4];
  logic [14:0] r_clamp;
  logic [1:0]  idx;
  tpm_pkg::qterm_t term;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] p_q;
  logic signed [ACCW-1:0] p60, acc_nx;
  logic [ACCW-1:0] pmag;
  logic        mneg;
  logic [tpm_pkg::QTW-1:0] qabs [4];
  logic [tpm_pkg::QTW-1:0] qmax01, qmax23, qmax;

  assign idx  = cnt_q[1:0];
  assign term = tpm_pkg::qmul_term(cnt_q[3:2], cnt_q[1:0]);
  assign r_clamp = (32'(rad_q) > RMAX) ? 15'(RMAX) : rad_q;

  assign qee[0] = qwx_q[31:16];
  assign qee[1] = qwx_q[15:0];
  assign qee[2] = qyz_q[31:16];
  assign qee[3] = qyz_q[15:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i]    = s_axis_tdata[16*i +: 16];
      hs_e[i]   = seen_q ? hs_q[i] : cur[i];
      prev_e[i] = seen_q ? prev_q[i] : cur[i];
      anch_e[i] = seen_q ? anch_q[i] : cur[i];
      cand_d[i] = en_q ? 18'(anch_e[i]) + 18'(cur[i]) - 18'(prev_e[i]) : 18'(cur[i]);
      tgt_d[i]  = 19'(rs_q[i]) + 19'(cand_d[i]) - 19'(hs_e[i]);
    end
    for (int i = 0; i < 4; i++) begin
      qin[i]  = s_axis_tdata[48 + 16*i +: 16];
      qabs[i] = qt_q[i][tpm_pkg::QTW-1] ? unsigned'(-qt_q[i]) : unsigned'(qt_q[i]);
    end
  end

  assign qmax01 = (qabs[0] > qabs[1]) ? qabs[0] : qabs[1];
  assign qmax23 = (qabs[2] > qabs[3]) ? qabs[2] : qabs[3];
  assign qmax   = (qmax01 > qmax23) ? qmax01 : qmax23;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mneg  = 1'b0;
    case (state_q)
      ST_POS: begin
        if (idx == 2'd3) begin
          mul_a = MW'(r_clamp);
          mul_b = MW'(r_clamp);
        end else begin
          mul_a = MW'(tgt_q[idx]);
          mul_b = MW'(tgt_q[idx]);
        end
      end
      ST_PMUL: begin
        mul_a = MW'(tgt_q[idx]);
        mul_b = MW'(r_clamp);
      end
      ST_QD: begin
        mul_a = MW'(qcur_q[term.ai]);
        mul_b = MW'(qs_q[term.bi]);
        mneg  = term.neg ^ (term.bi != 2'd0);
      end
      ST_QT: begin
        mul_a = MW'(qd_q[term.ai]);
        mul_b = MW'(qee[term.bi]);
        mneg  = term.neg;
      end
      ST_N2: begin
        mul_a = MW'(mag_q[idx][27:0]);
        mul_b = MW'(mag_q[idx][27:0]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  assign p60    = $signed(p_q[ACCW-1:0]);
  assign acc_nx = mneg ? acc_q - p60 : acc_q + p60;
  assign pmag   = p60[ACCW-1] ? unsigned'(-p60) : unsigned'(p60);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ph_q       <= 1'b0;
      en_q       <= 1'b0;
      rad_q      <= 15'd16384;
      qwx_q      <= {QONE, 16'h0000};
      qyz_q      <= '0;
      seen_q     <= 1'b0;
      clip_q     <= 1'b0;
      rr_q       <= '0;
      acc_q      <= '0;
      qneg_q     <= '0;
      mmax_q     <= '0;
      n_q        <= '0;
      pneg_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= 1'b0;
      sq_start_q <= 1'b0;
      sq_x_q     <= '0;
      dv_start_q <= 1'b0;
      dv_num_q   <= '0;
      dv_den_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        rs_q[i]   <= '0;
        hs_q[i]   <= '0;
        prev_q[i] <= '0;
        anch_q[i] <= '0;
        cand_q[i] <= '0;
        tgt_q[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        qs_q[i]   <= '0;
        qcur_q[i] <= '0;
        qd_q[i]   <= '0;
        qt_q[i]   <= '0;
        mag_q[i]  <= '0;
        qn_q[i]   <= '0;
      end
    end else begin
      sq_start_q <= 1'b0;
      dv_start_q <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          3'd0:    en_q    <= cfg_data_i[0];
          3'd1:    rad_q   <= cfg_data_i[14:0];
          3'd2:    rs_q[0] <= cfg_data_i[15:0];
          3'd3:    rs_q[1] <= cfg_data_i[15:0];
          3'd4:    rs_q[2] <= cfg_data_i[15:0];
          3'd5:    qwx_q   <= cfg_data_i;
          3'd6:    qyz_q   <= cfg_data_i;
          default: en_q    <= en_q;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            seen_q <= 1'b1;
            clip_q <= 1'b0;
            acc_q  <= '0;
            cnt_q  <= '0;
            ph_q   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              prev_q[i] <= cur[i];
              cand_q[i] <= cand_d[i];
              tgt_q[i]  <= tgt_d[i];
              if (!seen_q) begin
                hs_q[i]   <= cur[i];
                anch_q[i] <= cur[i];
              end
            end
            for (int i = 0; i < 4; i++) begin
              qcur_q[i] <= qin[i];
              if (!seen_q) begin
                qs_q[i] <= qin[i];
              end
            end
            state_q <= ST_POS;
          end
        end
        ST_POS: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (idx == 2'd3) begin
              rr_q    <= p_q[29:0];
              state_q <= ST_DECIDE;
            end else begin
              acc_q <= acc_nx;
            end
          end
        end
        ST_DECIDE: begin
          cnt_q <= '0;
          ph_q  <= 1'b0;
          if (en_q && (unsigned'(acc_q) > ACCW'(rr_q))) begin
            clip_q     <= 1'b1;
            sq_x_q     <= tpm_pkg::SQW'(unsigned'(acc_q)) << 16;
            sq_start_q <= 1'b1;
            state_q    <= ST_SQP;
          end else begin
            if (en_q) begin
              for (int i = 0; i < 3; i++) begin
                anch_q[i] <= tpm_pkg::sat16(20'(cand_q[i]));
              end
            end
            acc_q   <= '0;
            state_q <= ST_QD;
          end
        end
        ST_SQP: begin
          if (sq_done) begin
            n_q     <= sq_root;
            state_q <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            pneg_q     <= p60[ACCW-1];
            dv_num_q   <= (NW'(pmag) << 9) + NW'(n_q);
            dv_den_q   <= tpm_pkg::DIV_DW'(n_q) << 1;
            dv_start_q <= 1'b1;
            state_q    <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (dv_done) begin
            tgt_q[idx] <= 19'(tpm_pkg::sat_q16(pneg_q, dv_quo));
            ph_q       <= 1'b0;
            if (idx == 2'd2) begin
              cnt_q   <= '0;
              acc_q   <= '0;
              state_q <= ST_QD;
            end else begin
              cnt_q   <= cnt_q + 4'd1;
              state_q <= ST_PMUL;
            end
          end
        end
        ST_QD: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (idx == 2'd3) begin
              qd_q[cnt_q[3:2]] <= acc_nx[tpm_pkg::QDW-1:0];
              acc_q <= '0;
            end else begin
              acc_q <= acc_nx;
            end
            if (cnt_q == 4'd15) begin
              state_q <= ST_QT;
            end
          end
        end
        ST_QT: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (idx == 2'd3) begin
              qt_q[cnt_q[3:2]] <= acc_nx[tpm_pkg::QTW-1:0];
              acc_q <= '0;
            end else begin
              acc_q <= acc_nx;
            end
            if (cnt_q == 4'd15) begin
              state_q <= ST_MAX;
            end
          end
        end
        ST_MAX: begin
          for (int i = 0; i < 4; i++) begin
            mag_q[i]  <= qabs[i];
            qneg_q[i] <= qt_q[i][tpm_pkg::QTW-1];
          end
          mmax_q  <= qmax;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (mmax_q == '0) begin
            for (int i = 0; i < 4; i++) begin
              qn_q[i] <= '0;
            end
            state_q <= ST_OUT;
          end else if (mmax_q >= NORM_HI) begin
            mmax_q <= mmax_q >> 1;
            for (int i = 0; i < 4; i++) begin
              mag_q[i] <= mag_q[i] >> 1;
            end
          end else if (mmax_q < NORM_LO) begin
            mmax_q <= mmax_q << 1;
            for (int i = 0; i < 4; i++) begin
              mag_q[i] <= mag_q[i] << 1;
            end
          end else begin
            cnt_q   <= '0;
            ph_q    <= 1'b0;
            acc_q   <= '0;
            state_q <= ST_N2;
          end
        end
        ST_N2: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 4'd1;
            acc_q <= acc_nx;
            if (idx == 2'd3) begin
              sq_x_q     <= tpm_pkg::SQW'(unsigned'(acc_nx));
              sq_start_q <= 1'b1;
              state_q    <= ST_SQQ;
            end
          end
        end
        ST_SQQ: begin
          if (sq_done) begin
            n_q     <= sq_root;
            cnt_q   <= '0;
            state_q <= ST_QDS;
          end
        end
        ST_QDS: begin
          dv_num_q   <= (NW'(mag_q[idx][27:0]) << (QUAT_FRAC_BITS + 1)) + NW'(n_q);
          dv_den_q   <= tpm_pkg::DIV_DW'(n_q) << 1;
          dv_start_q <= 1'b1;
          state_q    <= ST_QDIV;
        end
        ST_QDIV: begin
          if (dv_done) begin
            qn_q[idx] <= tpm_pkg::sat_q16(qneg_q[idx], dv_quo);
            if (idx == 2'd3) begin
              state_q <= ST_OUT;
            end else begin
              cnt_q   <= cnt_q + 4'd1;
              state_q <= ST_QDS;
            end
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {qn_q[3], qn_q[2], qn_q[1], qn_q[0],
                          tpm_pkg::sat16(20'(tgt_q[2])),
                          tpm_pkg::sat16(20'(tgt_q[1])),
                          tpm_pkg::sat16(20'(tgt_q[0]))};
            m_user_q  <= clip_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  tpm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .x_i     (sq_x_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  tpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start_q),
    .num_i   (dv_num_q),
    .den_i   (dv_den_q),
    .busy_o  (dv_busy),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign cfg_ready_o   = 1'b1;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a transaction while busy");

  a_clip_needs_sphere: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> en_q)
    else $error("clip flagged with sphere disabled");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start_q |-> !dv_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire
